@@ sv/cffsd_pkg.sv @@
`default_nettype none
package cffsd_pkg;

   // Pool size and derived widths.
   localparam int MAX_SERVERS = 16;
   localparam int SRV_BITS    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_SERVERS + 1);
   localparam int TALLY_BITS  = 20;

   // Fixed field widths of the channels.
   localparam int CSR_BITS    = 5;
   localparam int ARRIVE_BITS = 31;
   localparam int TIME_BITS   = ARRIVE_BITS + 1;
   localparam int ID_BITS     = 4;
   localparam int COUNT_BITS  = 20;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 32;

   // Operation codes on the request side, kinds on the response side.
   localparam logic OP_DISPATCH   = 1'b0;
   localparam logic OP_REPORT     = 1'b1;
   localparam logic KIND_DISPATCH = 1'b0;
   localparam logic KIND_BUSIEST  = 1'b1;

   // One server's entry in the state memory.
   typedef struct packed {
      logic                  engaged;
      logic [TIME_BITS-1:0]  free_at;
      logic [TALLY_BITS-1:0] tally;
   } entry_type;

endpackage
`default_nettype wire

@@ sv/circular_first_free_server_dispatch.sv @@
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser = op, tdata = arrival, load
// rsp_      out        rsp_tvalid/rsp_tready  tuser = kind, tlast = last, tdata = rest
// csr_      in         csr_wr_en              csr_wr_data = servers in use
//
// Server state lives in one memory with a single read port, one entry per cycle.
// A dispatch first brings the rotation start below a reduced server count K by
// repeated subtraction, then reads all K servers from that start and registers
// its result. A report reads all K servers to find the top tally, then reads the
// servers again up to the last busiest one, offering one result per server at the
// top tally and waiting while the response side stalls. The next item is taken once the last result is registered.
// Reset is synchronous; per-entry valid bits make the memory read as zero at once.
module circular_first_free_server_dispatch (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // [30:0] arrival_time, [61:31] load_time, [63:62] zero
   input  wire  [cffsd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] op
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // [0] accepted, [4:1] server_id, [24:5] handled_count, [31:25] zero
   output logic [cffsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] kind
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire                                  csr_wr_en,
   input  wire  [cffsd_pkg::CSR_BITS-1:0]       csr_wr_data
);
   import cffsd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_DSP_SCAN,
      ST_DSP_OUT,
      ST_RPT_MAX,
      ST_RPT_RD,
      ST_RPT_CHK
   } state_type;

   localparam logic [TALLY_BITS-1:0] TALLY_TOP = '1;

   // Control registers.
   state_type             state_ff, state_in;
   logic [CSR_BITS-1:0]   csr_count_ff, csr_count_in;
   logic [SRV_BITS-1:0]   rot_ff, rot_in;
   logic [SRV_BITS-1:0]   cur_ff, cur_in;
   logic [CNT_BITS-1:0]   issued_ff, issued_in;
   logic                  pend_ff, pend_in;
   logic                  pend_last_ff, pend_last_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [SRV_BITS-1:0]    pidx_ff, pidx_in;
   logic [ARRIVE_BITS-1:0] arrival_ff, arrival_in;
   logic [ARRIVE_BITS-1:0] load_ff, load_in;
   logic [SRV_BITS-1:0]    pick_ff, pick_in;
   logic [TALLY_BITS-1:0]  pick_cnt_ff, pick_cnt_in;
   logic [TALLY_BITS-1:0]  best_ff, best_in;
   logic [SRV_BITS-1:0]    best_idx_ff, best_idx_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_acc_ff, rsp_acc_in;
   logic [SRV_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [TALLY_BITS-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Server memory, its valid bits and the read port.
   entry_type             mem [MAX_SERVERS];
   logic [MAX_SERVERS-1:0] valid_ff;
   entry_type             rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rd_en, wr_en;
   logic [SRV_BITS-1:0]   rd_addr, wr_addr;
   entry_type             wr_data;

   // Combinational helpers.
   logic [CNT_BITS-1:0]   k_active;
   logic [SRV_BITS-1:0]   cur_next, rot_next;
   logic                  out_free;
   entry_type             ent;
   logic                  still_busy;
   logic [TALLY_BITS-1:0] tally_inc;
   logic [TIME_BITS-1:0]  arrival_w;

   // Effective server count: zero acts as one, too many acts as the maximum.
   always_comb begin
      if (csr_count_ff == '0) begin
         k_active = CNT_BITS'(1);
      end else if (CNT_BITS'(csr_count_ff) > CNT_BITS'(MAX_SERVERS)) begin
         k_active = CNT_BITS'(MAX_SERVERS);
      end else begin
         k_active = CNT_BITS'(csr_count_ff);
      end
   end

   // Circular successors of the scan address and of the rotation start.
   assign cur_next = ((CNT_BITS'(cur_ff) + CNT_BITS'(1)) == k_active) ? '0 : cur_ff + 1'b1;
   assign rot_next = ((CNT_BITS'(rot_ff) + CNT_BITS'(1)) == k_active) ? '0 : rot_ff + 1'b1;

   // An entry never written reads as the reset value.
   assign ent        = rd_valid_ff ? rd_data_ff : '0;
   assign arrival_w  = {1'b0, arrival_ff};
   assign still_busy = ent.engaged && (ent.free_at > arrival_w);
   assign tally_inc  = (ent.tally == TALLY_TOP) ? ent.tally : ent.tally + 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next-state logic for the sequencer and the output register.
   always_comb begin
      state_in     = state_ff;
      csr_count_in = csr_wr_en ? csr_wr_data : csr_count_ff;
      rot_in       = rot_ff;
      cur_in       = cur_ff;
      issued_in    = issued_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      arrival_in   = arrival_ff;
      load_in      = load_ff;
      pick_in      = pick_ff;
      pick_cnt_in  = pick_cnt_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      wr_en        = 1'b0;
      wr_addr      = pidx_ff;
      wr_data      = ent;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               arrival_in  = req_tdata[ARRIVE_BITS-1:0];
               load_in     = req_tdata[2*ARRIVE_BITS-1:ARRIVE_BITS];
               issued_in   = '0;
               found_in    = 1'b0;
               pick_in     = '0;
               pick_cnt_in = '0;
               best_in     = '0;
               best_idx_in = '0;
               cur_in      = '0;
               state_in    = (req_tuser == OP_REPORT) ? ST_RPT_MAX : ST_NORM;
            end
         end

         // Bring the rotation start below the count after a count change.
         ST_NORM: begin
            if (CNT_BITS'(rot_ff) >= k_active) begin
               rot_in = rot_ff - SRV_BITS'(k_active);
            end else begin
               cur_in   = rot_ff;
               state_in = ST_DSP_SCAN;
            end
         end

         // Read every active server once from the rotation start, release it if
         // its time is up and take the first free one.
         ST_DSP_SCAN: begin
            if (issued_ff != k_active) begin
               rd_en        = 1'b1;
               cur_in       = cur_next;
               issued_in    = issued_ff + 1'b1;
               pend_in      = 1'b1;
               pend_last_in = (issued_ff + 1'b1) == k_active;
               pidx_in      = cur_ff;
            end
            if (pend_ff) begin
               if (!found_ff && !still_busy) begin
                  wr_en       = 1'b1;
                  wr_data     = '{engaged: 1'b1,
                                  free_at: arrival_w + {1'b0, load_ff},
                                  tally:   tally_inc};
                  found_in    = 1'b1;
                  pick_in     = pidx_ff;
                  pick_cnt_in = tally_inc;
               end else if (ent.engaged && !still_busy) begin
                  wr_en          = 1'b1;
                  wr_data.engaged = 1'b0;
               end
               if (pend_last_ff) begin
                  rot_in   = rot_next;
                  state_in = ST_DSP_OUT;
               end
            end
         end

         ST_DSP_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DISPATCH;
               rsp_acc_in   = found_ff;
               rsp_id_in    = pick_ff;
               rsp_cnt_in   = pick_cnt_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // First report pass: the top tally and the last server holding it.
         ST_RPT_MAX: begin
            if (issued_ff != k_active) begin
               rd_en        = 1'b1;
               cur_in       = cur_next;
               issued_in    = issued_ff + 1'b1;
               pend_in      = 1'b1;
               pend_last_in = (issued_ff + 1'b1) == k_active;
               pidx_in      = cur_ff;
            end
            if (pend_ff) begin
               if (ent.tally >= best_ff) begin
                  best_in     = ent.tally;
                  best_idx_in = pidx_ff;
               end
               if (pend_last_ff) begin
                  cur_in   = '0;
                  state_in = ST_RPT_RD;
               end
            end
         end

         // Second report pass: one item per server at the top tally.
         ST_RPT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_RPT_CHK;
         end

         ST_RPT_CHK: begin
            if (ent.tally != best_ff) begin
               cur_in   = cur_ff + 1'b1;
               state_in = ST_RPT_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_BUSIEST;
               rsp_acc_in   = 1'b0;
               rsp_id_in    = cur_ff;
               rsp_cnt_in   = best_ff;
               rsp_last_in  = cur_ff == best_idx_ff;
               cur_in       = cur_ff + 1'b1;
               state_in     = (cur_ff == best_idx_ff) ? ST_IDLE : ST_RPT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and output registers.
   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      arrival_ff  <= arrival_in;
      load_ff     <= load_in;
      pick_ff     <= pick_in;
      pick_cnt_ff <= pick_cnt_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_count_ff <= CSR_BITS'(MAX_SERVERS);
         rot_ff       <= '0;
         cur_ff       <= '0;
         issued_ff    <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_count_ff <= csr_count_in;
         rot_ff       <= rot_in;
         cur_ff       <= cur_in;
         issued_ff    <= issued_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Valid bits: an entry counts as written once it has been stored.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Server memory with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_cnt_ff[COUNT_BITS-1:0],
                                    ID_BITS'(rsp_id_ff),
                                    rsp_acc_ff});

endmodule
`default_nettype wire

@@ sv/cffsd_checker.sv @@
`default_nettype none
module cffsd_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [cffsd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire                              rsp_tuser,
   input wire                              rsp_tlast
);
   import cffsd_pkg::*;

   // Nothing is offered straight after a reset cycle.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response offered right after reset");

   // A dispatch outcome is always the only item of its request.
   a_dispatch_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DISPATCH) |-> rsp_tlast)
      else $error("dispatch outcome without last marker");

   // A dropped request names no server and no tally.
   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DISPATCH) && !rsp_tdata[0]
         |-> rsp_tdata[24:1] == '0)
      else $error("dropped request carries a server or tally");

   // Busiest-server entries never claim an accepted request.
   a_report_not_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_BUSIEST) |-> !rsp_tdata[0])
      else $error("report entry marked accepted");

   // A stalled item holds still.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind circular_first_free_server_dispatch cffsd_checker u_cffsd_checker (.*);
`default_nettype wire
